>>> src/dltq_pkg.sv
// Shared types and constants for the delta list timer queue.
package dltq_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TICK_WIDTH = 32;
    localparam int SLOT_W     = $clog2(NUM_TIMERS);
    localparam int LINK_W     = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(NUM_TIMERS);
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_STARTED  = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_STOPPED  = 3'd2,
        KIND_IGNORED  = 3'd3,
        KIND_REMAIN   = 3'd4,
        KIND_EXPIRED  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WALK,
        ST_INS_LINK,
        ST_REM_RD,
        ST_REM_FIX,
        ST_QRY_RD,
        ST_QRY_WALK,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_REARM,
        ST_OUT
    } state_t;

endpackage

>>> src/delta_list_timer_queue.sv
// Delta list timer queue: top level with the slot memory and its sequencer.
//
// Usage: one command transaction enters on the in channel (in_valid/in_stall)
// with mode, timer_id, duration and periodic. Results leave on the out
// channel (out_valid/out_stall) as kind, slot_id, remaining and last; last
// marks the final result of one command. Start, stop and query give one result
// each; a tick gives one result per expired timer, or none.
// The deltas and links live in one synchronous memory (one read port, one
// write port, registered read data). The list walk reads one entry per
// cycle. A start walks from the head to its insertion point, a stop unlinks
// the slot and folds its delta into the successor, a query walks from the
// slot back to the head and sums the deltas, and a tick checks the head,
// expires each due timer and then re-inserts every periodic one. A rejected
// start, an ignored stop or a query of an idle slot goes straight to its result.
// One command is in flight at a time; in_stall is high until every result of
// the previous command has been taken.
// Reset empties the list and clears running and repeat flags; the memory
// itself is not cleared. A stalled result holds in the output register.
module delta_list_timer_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic [3:0]                    timer_id,
    input  logic [31:0]                   duration,
    input  logic                          periodic,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    kind,
    output logic [3:0]                    slot_id,
    output logic [31:0]                   remaining,
    output logic                          last
);
    import dltq_pkg::*;

    typedef struct packed {
        logic [TICK_WIDTH-1:0] dlt;
        logic [LINK_W-1:0]     nxt;
        logic [LINK_W-1:0]     prv;
    } entry_t;

    // slot memory: delta and links
    entry_t mem [NUM_TIMERS];
    entry_t rd_data;
    logic   rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic   wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t wr_data;
    logic [TICK_WIDTH-1:0] period_mem [NUM_TIMERS];
    logic [TICK_WIDTH-1:0] per_rd;
    logic   per_wr;

    state_t state_reg, state_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] repeat_reg, repeat_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] cmd_id_reg, cmd_id_next;
    logic [TICK_WIDTH-1:0] cmd_dur_reg, cmd_dur_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] bef_reg, bef_next;
    logic [TICK_WIDTH-1:0] rest_reg, rest_next;
    logic [31:0] sum_reg, sum_next;
    logic [LINK_W-1:0] pn_reg, pn_next;          // neighbors of a removed slot
    logic [LINK_W-1:0] pp_reg, pp_next;
    logic [TICK_WIDTH-1:0] pd_reg, pd_next;
    logic [1:0] phase_reg, phase_next;
    logic tick_reg, tick_next;                   // command is a tick
    logic xl_reg, xl_next;                       // expiry ends the run
    logic [SLOT_W-1:0] rearm_id;
    logic rearm_any;
    logic tick_exp;
    state_t ret_reg, ret_next;                   // state after a result is taken
    logic ov_reg, ov_next;
    logic [2:0] ok_reg, ok_next;
    logic [3:0] os_reg, os_next;
    logic [31:0] or_reg, or_next;
    logic ol_reg, ol_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (per_wr)
        begin
            period_mem[cmd_id_reg] <= cmd_dur_reg;
        end
        per_rd <= period_mem[cmd_id_next];
    end

    // stack of expired periodic slots; pop in reverse expiry order
    logic [SLOT_W-1:0] stk_reg [NUM_TIMERS];
    logic [SLOT_W:0] sp_reg, sp_next;
    logic push;
    logic [SLOT_W-1:0] push_id;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_reg[sp_reg[SLOT_W-1:0]] <= push_id;
        end
    end

    assign rearm_any = (sp_reg != '0);
    assign rearm_id  = stk_reg[sp_reg[SLOT_W-1:0] - SLOT_W'(1)];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            running_reg <= '0;
            repeat_reg  <= '0;
            head_reg    <= NIL_SLOT;
            ov_reg      <= 1'b0;
            sp_reg      <= '0;
            ret_reg     <= ST_IDLE;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            repeat_reg  <= repeat_next;
            head_reg    <= head_next;
            ov_reg      <= ov_next;
            sp_reg      <= sp_next;
            ret_reg     <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_id_reg  <= cmd_id_next;
        cmd_dur_reg <= cmd_dur_next;
        cur_reg     <= cur_next;
        bef_reg     <= bef_next;
        rest_reg    <= rest_next;
        sum_reg     <= sum_next;
        pn_reg      <= pn_next;
        pp_reg      <= pp_next;
        pd_reg      <= pd_next;
        phase_reg   <= phase_next;
        tick_reg    <= tick_next;
        xl_reg      <= xl_next;
        ok_reg      <= ok_next;
        os_reg      <= os_next;
        or_reg      <= or_next;
        ol_reg      <= ol_next;
    end

    // hold off new commands until the last result has been taken
    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign kind      = ok_reg;
    assign slot_id   = os_reg;
    assign remaining = or_reg;
    assign last      = ol_reg;

    logic in_acc;
    logic id_ok;
    assign in_acc = in_valid && !in_stall;
    assign id_ok  = (32'(timer_id) < 32'(NUM_TIMERS));

    // head expires: already zero, or one on the first check of a tick
    assign tick_exp = (rd_data.dlt == '0) ||
                      (phase_reg == 2'd1 && rd_data.dlt == TICK_WIDTH'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (mode_t'(mode))
                        MODE_START:
                        begin
                            if (!id_ok || running_reg[timer_id[SLOT_W-1:0]] ||
                                duration == '0)
                                state_next = ST_OUT;
                            else
                                state_next = ST_INS_RD;
                        end
                        MODE_STOP:
                        begin
                            if (!id_ok || !running_reg[timer_id[SLOT_W-1:0]])
                                state_next = ST_OUT;
                            else
                                state_next = ST_REM_RD;
                        end
                        MODE_QUERY:
                        begin
                            if (!id_ok || !running_reg[timer_id[SLOT_W-1:0]])
                                state_next = ST_OUT;
                            else
                                state_next = ST_QRY_RD;
                        end
                        default:
                        begin
                            if (head_reg == NIL_SLOT)
                                state_next = ST_IDLE;
                            else
                                state_next = ST_TICK_RD;
                        end
                    endcase
                end
            end
            ST_INS_RD:   state_next = (cur_reg == NIL_SLOT) ? ST_INS_LINK : ST_INS_WALK;
            ST_INS_WALK:
            begin
                if (rest_reg < rd_data.dlt || rd_data.nxt == NIL_SLOT)
                    state_next = ST_INS_LINK;
                else
                    state_next = ST_INS_WALK;
            end
            ST_INS_LINK: state_next = (phase_reg == 2'd2) ?
                             (tick_reg ? ST_REARM : ST_OUT) : ST_INS_LINK;
            ST_REM_RD:   state_next = ST_REM_FIX;
            ST_REM_FIX:  state_next = (phase_reg == 2'd2) ? ST_OUT : ST_REM_FIX;
            ST_QRY_RD:   state_next = (rd_data.prv == NIL_SLOT) ? ST_OUT : ST_QRY_WALK;
            ST_QRY_WALK: state_next = (rd_data.prv == NIL_SLOT) ? ST_OUT : ST_QRY_WALK;
            ST_TICK_RD:  state_next = (head_reg == NIL_SLOT) ? ST_REARM : ST_TICK_CHK;
            ST_TICK_CHK:
            begin
                if (tick_exp)
                    state_next = ST_REM_RD;
                else
                    state_next = ST_REARM;
            end
            ST_REARM:
            begin
                if (ov_reg)
                    state_next = ST_REARM;
                else if (rearm_any)
                    state_next = ST_INS_RD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                    state_next = ret_reg;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        running_next = running_reg;
        repeat_next  = repeat_reg;
        head_next    = head_reg;
        cmd_id_next  = cmd_id_reg;
        cmd_dur_next = cmd_dur_reg;
        cur_next     = cur_reg;
        bef_next     = bef_reg;
        rest_next    = rest_reg;
        sum_next     = sum_reg;
        pn_next      = pn_reg;
        pp_next      = pp_reg;
        pd_next      = pd_reg;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        xl_next      = xl_reg;
        ret_next     = ret_reg;
        ov_next      = ov_reg && out_stall;
        ok_next      = ok_reg;
        os_next      = os_reg;
        or_next      = or_reg;
        ol_next      = ol_reg;
        sp_next      = sp_reg;
        push         = 1'b0;
        push_id      = cmd_id_reg;
        rd_en        = 1'b0;
        rd_addr      = cur_reg[SLOT_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = cmd_id_reg;
        wr_data      = '{dlt: rest_reg, nxt: cur_reg, prv: bef_reg};
        per_wr       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_id_next  = timer_id[SLOT_W-1:0];
                    cmd_dur_next = duration;
                    tick_next    = 1'b0;
                    phase_next   = 2'd0;
                    sum_next     = '0;
                    ok_next      = 3'(KIND_REMAIN);
                    os_next      = timer_id;
                    or_next      = '0;
                    ol_next      = 1'b1;
                    ret_next     = ST_IDLE;
                    cur_next     = head_reg;
                    bef_next     = NIL_SLOT;
                    rest_next    = duration;
                    case (mode_t'(mode))
                        MODE_START:
                        begin
                            if (!id_ok || running_reg[timer_id[SLOT_W-1:0]] ||
                                duration == '0)
                                ok_next = 3'(KIND_REJECTED);
                            else
                            begin
                                ok_next = 3'(KIND_STARTED);
                                repeat_next[timer_id[SLOT_W-1:0]] = periodic;
                            end
                            rd_en   = 1'b1;
                            rd_addr = head_reg[SLOT_W-1:0];
                        end
                        MODE_STOP:
                        begin
                            if (!id_ok || !running_reg[timer_id[SLOT_W-1:0]])
                                ok_next = 3'(KIND_IGNORED);
                            else
                                ok_next = 3'(KIND_STOPPED);
                            rd_en   = 1'b1;
                            rd_addr = timer_id[SLOT_W-1:0];
                        end
                        MODE_QUERY:
                        begin
                            rd_en   = 1'b1;
                            rd_addr = timer_id[SLOT_W-1:0];
                        end
                        default:
                        begin
                            tick_next = 1'b1;
                            phase_next = 2'd1;  // first head read decrements
                            ret_next  = ST_TICK_RD;
                            rd_en     = 1'b1;
                            rd_addr   = head_reg[SLOT_W-1:0];
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                // head entry is on rd_data; store the period, or load it on a re-arm
                per_wr = !tick_reg;
                if (tick_reg)
                    rest_next = per_rd;
            end
            ST_INS_WALK:
            begin
                if (rest_reg < rd_data.dlt)
                begin
                    pd_next = rd_data.dlt - rest_reg;
                end
                else
                begin
                    rest_next = rest_reg - rd_data.dlt;
                    bef_next  = cur_reg;
                    cur_next  = rd_data.nxt;
                    pd_next   = '0;
                    if (rd_data.nxt != NIL_SLOT)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_data.nxt[SLOT_W-1:0];
                    end
                end
                pn_next = rd_data.nxt;
                pp_next = rd_data.prv;
                phase_next = 2'd0;
            end
            ST_INS_LINK:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        // write new entry, link successor
                        wr_en   = 1'b1;
                        wr_addr = cmd_id_reg;
                        wr_data = '{dlt: rest_reg, nxt: cur_reg, prv: bef_reg};
                        running_next[cmd_id_reg] = 1'b1;
                        if (bef_reg == NIL_SLOT)
                            head_next = {1'b0, cmd_id_reg};
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        if (cur_reg != NIL_SLOT)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = cur_reg[SLOT_W-1:0];
                            wr_data = '{dlt: pd_reg, nxt: pn_reg, prv: {1'b0, cmd_id_reg}};
                        end
                        rd_en   = 1'b1;
                        rd_addr = bef_reg[SLOT_W-1:0];
                        phase_next = 2'd3;
                    end
                    2'd3:
                    begin
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        if (bef_reg != NIL_SLOT)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = bef_reg[SLOT_W-1:0];
                            wr_data = '{dlt: rd_data.dlt, nxt: {1'b0, cmd_id_reg},
                                        prv: rd_data.prv};
                        end
                        phase_next = 2'd0;
                        if (tick_reg)
                            sp_next = sp_reg - 1'b1;
                    end
                endcase
            end
            ST_REM_RD:
            begin
                // removed entry arrives: read successor; an expired head has delta zero
                pn_next = rd_data.nxt;
                pp_next = rd_data.prv;
                pd_next = tick_reg ? '0 : rd_data.dlt;
                rd_en   = 1'b1;
                rd_addr = rd_data.nxt[SLOT_W-1:0];
                phase_next = 2'd0;
            end
            ST_REM_FIX:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        if (pn_reg != NIL_SLOT)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pn_reg[SLOT_W-1:0];
                            wr_data = '{dlt: rd_data.dlt + pd_reg, nxt: rd_data.nxt,
                                        prv: pp_reg};
                        end
                        // the run goes on only while the successor is also due
                        if (tick_reg)
                            xl_next = (pn_reg == NIL_SLOT) || (rd_data.dlt != '0);
                        rd_en   = 1'b1;
                        rd_addr = pp_reg[SLOT_W-1:0];
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        phase_next = 2'd3;
                    end
                    2'd3:
                    begin
                        if (pp_reg != NIL_SLOT)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pp_reg[SLOT_W-1:0];
                            wr_data = '{dlt: rd_data.dlt, nxt: pn_reg, prv: rd_data.prv};
                        end
                        else
                            head_next = pn_reg;
                        running_next[cmd_id_reg] = 1'b0;
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        phase_next = 2'd0;
                        if (tick_reg)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = head_reg[SLOT_W-1:0];
                        end
                    end
                endcase
            end
            ST_QRY_RD:
            begin
                sum_next = rd_data.dlt[31:0];
                if (rd_data.prv == NIL_SLOT)
                    or_next = rd_data.dlt[31:0];
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = rd_data.prv[SLOT_W-1:0];
                end
            end
            ST_QRY_WALK:
            begin
                sum_next = sum_reg + rd_data.dlt[31:0];
                if (rd_data.prv == NIL_SLOT)
                    or_next = sum_reg + rd_data.dlt[31:0];
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_data.prv[SLOT_W-1:0];
                end
            end
            ST_TICK_RD:
            begin
                // head entry is on rd_data
            end
            ST_TICK_CHK:
            begin
                cmd_id_next = head_reg[SLOT_W-1:0];
                if (phase_reg == 2'd1 && rd_data.dlt != '0)
                begin
                    // decrement once per tick
                    wr_en   = 1'b1;
                    wr_addr = head_reg[SLOT_W-1:0];
                    wr_data = '{dlt: rd_data.dlt - 1'b1, nxt: rd_data.nxt,
                                prv: rd_data.prv};
                end
                phase_next = 2'd0;
                if (tick_exp)
                begin
                    pn_next  = rd_data.nxt;
                    pp_next  = NIL_SLOT;
                    pd_next  = '0;
                    if (repeat_reg[head_reg[SLOT_W-1:0]])
                    begin
                        push    = 1'b1;
                        push_id = head_reg[SLOT_W-1:0];
                        sp_next = sp_reg + 1'b1;
                    end
                    rd_en   = 1'b1;
                    rd_addr = head_reg[SLOT_W-1:0];
                end
            end
            ST_REARM:
            begin
                if (!ov_reg && rearm_any)
                begin
                    cmd_id_next = rearm_id;
                    cur_next    = head_reg;
                    bef_next    = NIL_SLOT;
                    phase_next  = 2'd0;
                    rd_en       = 1'b1;
                    rd_addr     = head_reg[SLOT_W-1:0];
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    // load an expiry only once the output register is free
                    if (tick_reg)
                    begin
                        ok_next = 3'(KIND_EXPIRED);
                        os_next = 4'(cmd_id_reg);
                        or_next = '0;
                        ol_next = xl_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> src/dltq_checker.sv
// Port-level checker for the delta list timer queue, bound to the top level.
module dltq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  kind,
    input logic [31:0] remaining,
    input logic [1:0]  mode
);
    import dltq_pkg::*;

    // results beyond the known kinds never appear
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind <= 3'(KIND_EXPIRED)))
        else $error("bad result kind");

    // only remaining answers carry a nonzero value
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != 3'(KIND_REMAIN) |-> remaining == '0)
        else $error("remaining set on a non-query result");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind))
        else $error("stalled result changed");

    // a command other than tick is never accepted back to back
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode != 2'(MODE_TICK) |=> in_stall)
        else $error("command accepted while busy");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .remaining(remaining), .mode(mode)
);

>>> bench/tb_delta_list_timer_queue.sv
// Testbench for the delta list timer queue: directed and random commands checked against a predictor.
module tb_delta_list_timer_queue;
    import dltq_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [4:0] NO_SLOT = 5'd16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_TICK;
    logic [3:0]  timer_id = '0;
    logic [31:0] duration = '0;
    logic        periodic = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [3:0]  slot_id;
    logic [31:0] remaining;
    logic        last;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] remaining;
        logic        last;
    } timer_result_t;

    // Results the predictor says are still owed by the block, oldest first.
    timer_result_t pending_results[$];

    // Predictor copy of the timer list.
    logic [31:0] slot_delta [NSLOT];
    logic [31:0] slot_period[NSLOT];
    logic        slot_repeat[NSLOT];
    logic        slot_running[NSLOT];
    logic [4:0]  slot_next[NSLOT];
    logic [4:0]  slot_prev[NSLOT];
    logic [4:0]  list_head;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int hold_req = 0;
    int mismatches = 0;

    delta_list_timer_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .timer_id(timer_id), .duration(duration), .periodic(periodic),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .slot_id(slot_id), .remaining(remaining), .last(last)
    );

    always #10 clk = ~clk;

    // Link slot q into the list at the point where its ticks run out; ties go after.
    task automatic list_link(input int q, input logic [31:0] ticks);
        logic [4:0]  prior;
        logic [4:0]  cur;
        logic [31:0] rest;
        prior = NO_SLOT;
        cur = list_head;
        rest = ticks;
        while (cur != NO_SLOT) begin
            if (rest < slot_delta[cur]) begin
                slot_delta[cur] = slot_delta[cur] - rest;
                break;
            end
            rest = rest - slot_delta[cur];
            prior = cur;
            cur = slot_next[cur];
        end
        slot_delta[q] = rest;
        slot_prev[q] = prior;
        slot_next[q] = cur;
        if (prior != NO_SLOT)
            slot_next[prior] = q[4:0];
        else
            list_head = q[4:0];
        if (cur != NO_SLOT)
            slot_prev[cur] = q[4:0];
        slot_running[q] = 1'b1;
    endtask

    // Unlink slot q and hand its delta to the successor.
    task automatic list_unlink(input int q);
        logic [4:0] p;
        logic [4:0] n;
        p = slot_prev[q];
        n = slot_next[q];
        if (p != NO_SLOT)
            slot_next[p] = n;
        else
            list_head = n;
        if (n != NO_SLOT) begin
            slot_delta[n] = slot_delta[n] + slot_delta[q];
            slot_prev[n] = p;
        end
        slot_next[q] = NO_SLOT;
        slot_prev[q] = NO_SLOT;
        slot_running[q] = 1'b0;
    endtask

    // Apply one command to the predicted list and queue the results it causes.
    task automatic timer_list_apply(input mode_t m, input int id, input logic [31:0] dur,
                                    input logic per);
        timer_result_t r;
        logic [31:0]   sum;
        logic [4:0]    cur;
        int            rearm[$];
        int            t;
        int            count;
        int            first;
        r = '0;
        r.slot = id[3:0];
        r.last = 1'b1;
        case (m)
            MODE_START: begin
                if (slot_running[id] || dur == 0) begin
                    r.kind = KIND_REJECTED;
                end else begin
                    slot_period[id] = dur;
                    slot_repeat[id] = per;
                    list_link(id, dur);
                    r.kind = KIND_STARTED;
                end
                pending_results.push_back(r);
            end
            MODE_STOP: begin
                if (slot_running[id]) begin
                    list_unlink(id);
                    r.kind = KIND_STOPPED;
                end else begin
                    r.kind = KIND_IGNORED;
                end
                pending_results.push_back(r);
            end
            MODE_QUERY: begin
                sum = '0;
                if (slot_running[id]) begin
                    cur = id[4:0];
                    while (cur != NO_SLOT) begin
                        sum = sum + slot_delta[cur];
                        cur = slot_prev[cur];
                    end
                end
                r.kind = KIND_REMAIN;
                r.remaining = sum;
                pending_results.push_back(r);
            end
            default: begin
                if (list_head != NO_SLOT) begin
                    count = 0;
                    first = pending_results.size();
                    if (slot_delta[list_head] > 0)
                        slot_delta[list_head] = slot_delta[list_head] - 1;
                    // expire the head and every zero-delta follower in list order
                    while (list_head != NO_SLOT && slot_delta[list_head] == 0 && count < NSLOT)
                    begin
                        t = list_head;
                        list_unlink(t);
                        r.kind = KIND_EXPIRED;
                        r.slot = t[3:0];
                        r.last = 1'b0;
                        pending_results.push_back(r);
                        count++;
                        if (slot_repeat[t])
                            rearm.push_back(t);
                    end
                    if (count > 0)
                        pending_results[first + count - 1].last = 1'b1;
                    // re-arm periodic timers in reverse expiry order
                    while (rearm.size() > 0) begin
                        t = rearm.pop_back();
                        list_link(t, slot_period[t]);
                    end
                end
            end
        endcase
    endtask

    // Offer one command transaction and hold it until the block takes it.
    // Called at a rising edge; valid stays up until the next command or an idle cycle.
    task automatic send_cmd(input mode_t m, input int id, input logic [31:0] dur,
                            input logic per);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        timer_id <= id[3:0];
        duration <= dur;
        periodic <= per;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        timer_list_apply(m, id, dur, per);
    endtask

    // Pick a short duration most of the time so ticks actually expire timers.
    function automatic logic [31:0] pick_duration();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            return 32'd0;
        else if (sel < 10)
            return $urandom();
        else if (sel < 13)
            return 32'hFFFF_FFFF;
        return $urandom_range(1, 6);
    endfunction

    task automatic run_random(input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 35)
                send_cmd(MODE_START, $urandom_range(0, 15), pick_duration(), $urandom_range(0, 1));
            else if (sel < 47)
                send_cmd(MODE_STOP, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
            else if (sel < 65)
                send_cmd(MODE_QUERY, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
            else
                send_cmd(MODE_TICK, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
        end
    endtask

    task automatic test_directed();
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);            // tick on an empty list
        send_cmd(MODE_START, 0, 32'd0, 1'b1);           // zero duration is rejected
        send_cmd(MODE_STOP, 3, 32'd0, 1'b0);            // stop of an idle slot
        send_cmd(MODE_QUERY, 3, 32'd0, 1'b0);           // query of an idle slot
        send_cmd(MODE_START, 15, 32'hFFFF_FFFF, 1'b0);  // largest duration
        send_cmd(MODE_START, 15, 32'd5, 1'b0);          // already running
        send_cmd(MODE_START, 0, 32'd2, 1'b1);
        send_cmd(MODE_START, 1, 32'd2, 1'b0);           // tie goes after slot 0
        send_cmd(MODE_START, 2, 32'd3, 1'b1);
        send_cmd(MODE_QUERY, 2, 32'd0, 1'b0);
        send_cmd(MODE_QUERY, 15, 32'd0, 1'b0);
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);            // no expiry
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);            // slots 0 and 1 expire together
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);
        send_cmd(MODE_STOP, 15, 32'd0, 1'b0);
        send_cmd(MODE_START, 7, 32'h8000_0001, 1'b1);
        send_cmd(MODE_QUERY, 7, 32'd0, 1'b0);
        send_cmd(MODE_STOP, 7, 32'd0, 1'b0);
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);
        send_cmd(MODE_TICK, 0, 32'd0, 1'b0);
    endtask

    task automatic test_idle_phases();
        idle_pct = 0;  stall_pct = 0;  run_random(50);
        idle_pct = 77; stall_pct = 0;  run_random(50);
        idle_pct = 0;  stall_pct = 77; run_random(50);
        idle_pct = 12; stall_pct = 12; run_random(50);
    endtask

    // Hold the output off for a long stretch while commands keep coming.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 300;
        run_random(20);
    endtask

    // Receiver side: random stall, or a long counted hold when requested.
    always @(posedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        timer_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d slot %0d remaining %0d last %0d",
                             kind, slot_id, remaining, last);
            end else begin
                e = pending_results.pop_front();
                if (kind !== e.kind || slot_id !== e.slot || remaining !== e.remaining
                    || last !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected kind %0d slot %0d rem %0d last %0d,",
                                  " got %0d %0d %0d %0d"},
                                 e.kind, e.slot, e.remaining, e.last,
                                 kind, slot_id, remaining, last);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            slot_delta[i] = '0;
            slot_period[i] = '0;
            slot_repeat[i] = 1'b0;
            slot_running[i] = 1'b0;
            slot_next[i] = NO_SLOT;
            slot_prev[i] = NO_SLOT;
        end
        list_head = NO_SLOT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_idle_phases();
        test_backpressure();
        in_valid <= 1'b0;
        stall_pct = 0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
